>>> design/pkas_pkg.sv
// ============================================================================
// pkas_pkg: shared types and constants for the pair-key association stack
// Holds the capacity, derived widths, transaction payload structs, operation
// and error codes, and the command/status bundles between the controller
// and the datapath.
// ============================================================================
`default_nettype none

package pkas_pkg;

    // Capacity and derived widths.
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 64;
    localparam int FILL_W      = 7;

    // Operation codes.
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_FIND = 2'd1;
    localparam logic [1:0] ACT_POP  = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

    // Read address selection for the entry memory.
    localparam logic [1:0] RD_TOP   = 2'd0;
    localparam logic [1:0] RD_FIRST = 2'd1;
    localparam logic [1:0] RD_NEXT  = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]        action;
        logic [WORD_W-1:0] key_first;
        logic [WORD_W-1:0] key_second;
        logic [WORD_W-1:0] push_value;
    } in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [WORD_W-1:0] result_value;
        logic              found;
        logic [1:0]        error_code;
        logic [FILL_W-1:0] fill_count;
    } out_t;

    // One stored triple.
    typedef struct packed {
        logic [WORD_W-1:0] key_first;
        logic [WORD_W-1:0] key_second;
        logic [WORD_W-1:0] value;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       push_wr;
        logic       cnt_dec;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       res_clear;
        logic [1:0] res_err;
        logic       res_load;
        logic       emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] action;
        logic       empty;
        logic       full;
        logic       match;
        logic       scan_last;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> design/pair_key_association_stack_core.sv
// Sequence: a transaction is accepted in IDLE and decoded; push, no-op, rejected operations
// and a find on an empty store then go to the output register, a pop first reads the top
// entry, and a find scans from 1 to 64 entries, one per cycle, until a match or the last.
// One transaction at a time: the next is accepted once the result sits in the output
// register, later if an earlier result still waits there.
// Reset clears the entry count and all control state; the entry memory is not cleared.
// ============================================================================
// pair_key_association_stack_core: stack of (key, key, value) triples
// Push, pop and find-by-key-pair over a fixed-capacity entry memory, with a
// controller state machine driving a separate datapath.
// ============================================================================
`default_nettype none

module pair_key_association_stack_core (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_valid,
    output logic            s_ready,
    input  pkas_pkg::in_t   s_data,
    output logic            m_valid,
    input  wire             m_ready,
    output pkas_pkg::out_t  m_data
);

    pkas_pkg::cmd_t cmd;
    pkas_pkg::sts_t sts;

    pkas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pkas_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // The fill count never exceeds the capacity.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.fill_count <= pkas_pkg::FILL_W'(pkas_pkg::STACK_DEPTH)))
        else $error("fill count above capacity");

    // An overflow is only reported with the store full.
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.error_code == pkas_pkg::ERR_OVERFLOW)
        |-> (m_data.fill_count == pkas_pkg::FILL_W'(pkas_pkg::STACK_DEPTH)))
        else $error("overflow reported below capacity");

    // An underflow is only reported with the store empty and nothing found.
    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.error_code == pkas_pkg::ERR_UNDERFLOW)
        |-> (m_data.fill_count == '0 && !m_data.found))
        else $error("underflow reported with entries held");

    // Input is not taken while the sequencer is building a result.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en || cmd.res_clear || cmd.res_load) |-> !s_ready)
        else $error("input ready while a transaction is in progress");

endmodule

`default_nettype wire

>>> design/pkas_ctrl.sv
// ============================================================================
// pkas_ctrl: sequencing state machine
// Accepts one transaction at a time, decodes its operation, steps the entry
// scan for a find, and hands the result to the output register.
// ============================================================================
`default_nettype none

module pkas_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  pkas_pkg::sts_t   sts,
    output pkas_pkg::cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_POP_RD = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.res_clear = 1'b1;
                cmd.res_err   = pkas_pkg::ERR_OK;
                state_next    = ST_EMIT;
                case (sts.action)
                    pkas_pkg::ACT_PUSH: begin
                        if (sts.full) begin
                            cmd.res_err = pkas_pkg::ERR_OVERFLOW;
                        end else begin
                            cmd.push_wr = 1'b1;
                        end
                    end
                    pkas_pkg::ACT_FIND: begin
                        if (!sts.empty) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = pkas_pkg::RD_FIRST;
                            state_next = ST_SCAN;
                        end
                    end
                    pkas_pkg::ACT_POP: begin
                        if (sts.empty) begin
                            cmd.res_err = pkas_pkg::ERR_UNDERFLOW;
                        end else begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = pkas_pkg::RD_TOP;
                            cmd.cnt_dec = 1'b1;
                            state_next  = ST_POP_RD;
                        end
                    end
                    default: begin
                        // Unused operation: plain result, nothing changes.
                    end
                endcase
            end
            ST_POP_RD: begin
                cmd.res_load = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_SCAN: begin
                if (sts.match) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_EMIT;
                end else if (sts.scan_last) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = pkas_pkg::RD_NEXT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/pkas_dp.sv
// ============================================================================
// pkas_dp: entry memory, fill counter and result path
// Stores triples in a single-port-write, registered-read memory, keeps the
// entry count, compares keys during a scan and holds the output register.
// ============================================================================
`default_nettype none

module pkas_dp (
    input  wire             aclk,
    input  wire             aresetn,
    input  pkas_pkg::in_t   s_data,
    input  pkas_pkg::cmd_t  cmd,
    output pkas_pkg::sts_t  sts,
    output logic            m_valid,
    input  wire             m_ready,
    output pkas_pkg::out_t  m_data
);

    pkas_pkg::entry_t                   mem [pkas_pkg::STACK_DEPTH];
    pkas_pkg::entry_t                   rd_data_reg;
    pkas_pkg::in_t                      item_reg;
    logic [pkas_pkg::CNT_W-1:0]         count_reg;
    logic [pkas_pkg::ADDR_W-1:0]        scan_idx_reg;
    logic [pkas_pkg::ADDR_W-1:0]        rd_addr;
    logic [pkas_pkg::CNT_W-1:0]         top_idx;
    logic [pkas_pkg::CNT_W-1:0]         scan_next_cnt;
    logic [pkas_pkg::WORD_W-1:0]        res_value_reg;
    logic                               res_found_reg;
    logic [1:0]                         res_err_reg;
    logic                               m_valid_reg;
    pkas_pkg::out_t                     out_reg;
    pkas_pkg::entry_t                   wr_entry;

    // Captured transaction.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
    end

    // Address arithmetic for pop and scan.
    assign top_idx       = count_reg - pkas_pkg::CNT_W'(1);
    assign scan_next_cnt = pkas_pkg::CNT_W'(scan_idx_reg) + pkas_pkg::CNT_W'(1);

    always_comb begin
        case (cmd.rd_sel)
            pkas_pkg::RD_TOP:   rd_addr = top_idx[pkas_pkg::ADDR_W-1:0];
            pkas_pkg::RD_FIRST: rd_addr = '0;
            pkas_pkg::RD_NEXT:  rd_addr = scan_next_cnt[pkas_pkg::ADDR_W-1:0];
            default:            rd_addr = '0;
        endcase
    end

    assign wr_entry.key_first  = item_reg.key_first;
    assign wr_entry.key_second = item_reg.key_second;
    assign wr_entry.value      = item_reg.push_value;

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.push_wr) begin
            mem[count_reg[pkas_pkg::ADDR_W-1:0]] <= wr_entry;
        end
        if (cmd.rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            scan_idx_reg <= rd_addr;
        end
    end

    // Entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.push_wr) begin
            count_reg <= count_reg + pkas_pkg::CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            count_reg <= top_idx;
        end
    end

    // Result being built for the current transaction.
    always_ff @(posedge aclk) begin
        if (cmd.res_clear) begin
            res_value_reg <= '0;
            res_found_reg <= 1'b0;
            res_err_reg   <= cmd.res_err;
        end else if (cmd.res_load) begin
            res_value_reg <= rd_data_reg.value;
            res_found_reg <= 1'b1;
        end
    end

    // Output register, decoupling the result channel from the sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.result_value <= res_value_reg;
            out_reg.found        <= res_found_reg;
            out_reg.error_code   <= res_err_reg;
            out_reg.fill_count   <= pkas_pkg::FILL_W'(count_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Status toward the controller.
    assign sts.action    = item_reg.action;
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == pkas_pkg::CNT_W'(pkas_pkg::STACK_DEPTH));
    assign sts.match     = (rd_data_reg.key_first == item_reg.key_first)
                        && (rd_data_reg.key_second == item_reg.key_second);
    assign sts.scan_last = (scan_next_cnt == count_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

endmodule

`default_nettype wire
